>>> design/brs_pkg.sv
package brs_pkg;

    localparam int WORD_BITS     = 64;
    localparam int OFF_W         = 6;
    localparam int POS_W         = 17;
    localparam int WPOS_W        = POS_W - OFF_W;
    localparam int OP_W          = 3;
    localparam int SW_W          = 6;
    localparam int SW_MAX        = 32;
    localparam int BLK_W         = 5;
    localparam int STAT_W        = 2;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_W         = 17;
    localparam int MAX_WORDS_DEF = 1024;
    localparam int SEL_K_W       = 7;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD   = 3'd0,
        OP_ACCESS = 3'd1,
        OP_RANK1  = 3'd2,
        OP_RANK0  = 3'd3,
        OP_SEL1   = 3'd4,
        OP_SEL0   = 3'd5,
        OP_NEXT1  = 3'd6,
        OP_RSVD   = 3'd7
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_RANGE     = 2'd1,
        STAT_ZERO      = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } stat_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SAMPLE = 1'b0,
        REG_LENGTH = 1'b1
    } cfg_reg_t;

    typedef enum logic [4:0] {
        CMD_NOP,
        CMD_LATCH,
        CMD_EARLY,
        CMD_LOAD,
        CMD_DIV_INIT,
        CMD_DIV_STEP,
        CMD_SAMPLE_RD,
        CMD_SAMPLE_ACC,
        CMD_WORD_RD,
        CMD_RANK_ACC,
        CMD_RANK_LAST,
        CMD_SCAN_INIT,
        CMD_SCAN_ACC,
        CMD_NOT_FOUND,
        CMD_FIND_BYTE,
        CMD_FIND_BIT,
        CMD_EMIT
    } cmd_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_DIV,
        S_SAMPLE_RD,
        S_SAMPLE_ACC,
        S_RANK_RD,
        S_RANK_ACC,
        S_SCAN_RD,
        S_SCAN_ACC,
        S_FIND_BYTE,
        S_FIND_BIT,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic early;
        logic is_load;
        logic is_rank;
        logic div_last;
        logic scan_end;
        logic found;
        logic out_free;
    } dp_status_t;

    // ones in a 64-bit word
    function automatic logic [OFF_W:0] pop64(input logic [WORD_BITS-1:0] x);
        logic [OFF_W:0] c;
        c = '0;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            c = c + (OFF_W+1)'(x[i]);
        end
        return c;
    endfunction

    // ones in a byte
    function automatic logic [3:0] pop8(input logic [7:0] x);
        logic [3:0] c;
        c = '0;
        for (int i = 0; i < 8; i++)
        begin
            c = c + 4'(x[i]);
        end
        return c;
    endfunction

endpackage

>>> design/brs_ctrl.sv
module brs_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  brs_pkg::dp_status_t stat,
    output brs_pkg::cmd_t       cmd
);

    brs_pkg::state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= brs_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = brs_pkg::CMD_NOP;
        in_ready   = 1'b0;
        case (state_reg)
            brs_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd        = brs_pkg::CMD_LATCH;
                    state_next = brs_pkg::S_DISPATCH;
                end
            end
            brs_pkg::S_DISPATCH:
            begin
                if (stat.early)
                begin
                    cmd        = brs_pkg::CMD_EARLY;
                    state_next = brs_pkg::S_EMIT;
                end
                else if (stat.is_load)
                begin
                    cmd        = brs_pkg::CMD_LOAD;
                    state_next = brs_pkg::S_EMIT;
                end
                else if (stat.is_rank)
                begin
                    cmd        = brs_pkg::CMD_DIV_INIT;
                    state_next = brs_pkg::S_DIV;
                end
                else
                begin
                    cmd        = brs_pkg::CMD_SCAN_INIT;
                    state_next = brs_pkg::S_SCAN_RD;
                end
            end
            brs_pkg::S_DIV:
            begin
                cmd = brs_pkg::CMD_DIV_STEP;
                if (stat.div_last)
                    state_next = brs_pkg::S_SAMPLE_RD;
            end
            brs_pkg::S_SAMPLE_RD:
            begin
                cmd        = brs_pkg::CMD_SAMPLE_RD;
                state_next = brs_pkg::S_SAMPLE_ACC;
            end
            brs_pkg::S_SAMPLE_ACC:
            begin
                cmd        = brs_pkg::CMD_SAMPLE_ACC;
                state_next = brs_pkg::S_RANK_RD;
            end
            brs_pkg::S_RANK_RD:
            begin
                cmd        = brs_pkg::CMD_WORD_RD;
                state_next = brs_pkg::S_RANK_ACC;
            end
            brs_pkg::S_RANK_ACC:
            begin
                if (stat.scan_end)
                begin
                    cmd        = brs_pkg::CMD_RANK_LAST;
                    state_next = brs_pkg::S_EMIT;
                end
                else
                begin
                    cmd        = brs_pkg::CMD_RANK_ACC;
                    state_next = brs_pkg::S_RANK_RD;
                end
            end
            brs_pkg::S_SCAN_RD:
            begin
                if (stat.scan_end)
                begin
                    cmd        = brs_pkg::CMD_NOT_FOUND;
                    state_next = brs_pkg::S_EMIT;
                end
                else
                begin
                    cmd        = brs_pkg::CMD_WORD_RD;
                    state_next = brs_pkg::S_SCAN_ACC;
                end
            end
            brs_pkg::S_SCAN_ACC:
            begin
                cmd = brs_pkg::CMD_SCAN_ACC;
                if (stat.found)
                    state_next = brs_pkg::S_FIND_BYTE;
                else
                    state_next = brs_pkg::S_SCAN_RD;
            end
            brs_pkg::S_FIND_BYTE:
            begin
                cmd        = brs_pkg::CMD_FIND_BYTE;
                state_next = brs_pkg::S_FIND_BIT;
            end
            brs_pkg::S_FIND_BIT:
            begin
                cmd        = brs_pkg::CMD_FIND_BIT;
                state_next = brs_pkg::S_EMIT;
            end
            brs_pkg::S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd        = brs_pkg::CMD_EMIT;
                    state_next = brs_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = brs_pkg::S_IDLE;
            end
        endcase
    end

    // a transaction is only taken with the engine idle
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ready && in_valid) |=> (state_reg == brs_pkg::S_DISPATCH))
        else $error("accepted transaction did not start dispatch");

    a_emit_return: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd == brs_pkg::CMD_EMIT) |=> (state_reg == brs_pkg::S_IDLE))
        else $error("emit did not return to idle");

    a_div_path: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == brs_pkg::S_SAMPLE_RD) |-> ($past(state_reg) == brs_pkg::S_DIV))
        else $error("sample read without block division");

endmodule

>>> design/brs_dp.sv
module brs_dp
#(
    parameter int MAX_WORDS = brs_pkg::MAX_WORDS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  brs_pkg::cmd_t                     cmd,
    output brs_pkg::dp_status_t               stat,
    input  logic                              cfg_we,
    input  logic [brs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [brs_pkg::CFG_W-1:0]         cfg_data,
    input  logic [brs_pkg::OP_W-1:0]          in_opcode,
    input  logic [brs_pkg::POS_W-1:0]         in_position,
    input  logic [brs_pkg::WORD_BITS-1:0]     in_data_word,
    input  logic                              out_ready,
    output logic                              out_valid,
    output logic                              out_bit_value,
    output logic [brs_pkg::POS_W-1:0]         out_answer,
    output logic [brs_pkg::STAT_W-1:0]        out_status
);

    localparam int IDX_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int CNT_W = $clog2(MAX_WORDS + 1);
    localparam int CMP_W = (CNT_W > brs_pkg::WPOS_W) ? CNT_W : brs_pkg::WPOS_W;
    localparam int unsigned CAP = MAX_WORDS * brs_pkg::WORD_BITS;
    localparam int POS_W = brs_pkg::POS_W;
    localparam int WPOS_W = brs_pkg::WPOS_W;
    localparam int OFF_W = brs_pkg::OFF_W;
    localparam int WB = brs_pkg::WORD_BITS;
    localparam int KW = brs_pkg::SEL_K_W;

    // configuration and load state
    logic [brs_pkg::SW_W-1:0] sample_words_reg;
    logic [POS_W-1:0]         bit_length_reg;
    logic [CNT_W-1:0]         words_loaded_reg;
    logic [POS_W-1:0]         running_ones_reg;
    logic [brs_pkg::BLK_W-1:0] blk_pos_reg;
    logic [IDX_W-1:0]         blk_idx_reg;

    // latched transaction
    brs_pkg::op_t             op_reg;
    logic [POS_W-1:0]         pos_reg;
    logic [WB-1:0]            data_reg;

    // work registers
    logic [WPOS_W-1:0]        cur_reg;
    logic [WPOS_W-1:0]        end_reg;
    logic [POS_W-1:0]         acc_reg;
    logic [WPOS_W-1:0]        dvd_reg;
    logic [WPOS_W-1:0]        quo_reg;
    logic [brs_pkg::SW_W-1:0] rmd_reg;
    logic [3:0]               div_cnt_reg;
    logic [WB-1:0]            m_reg;
    logic [2:0]               byte_sel_reg;
    logic [7:0]               byte_reg;

    // result staged for output
    logic                     res_bit_reg;
    logic [POS_W-1:0]         res_ans_reg;
    brs_pkg::stat_t           res_stat_reg;

    logic                     out_valid_reg;
    logic                     out_bit_reg;
    logic [POS_W-1:0]         out_ans_reg;
    logic [brs_pkg::STAT_W-1:0] out_stat_reg;

    // memories
    logic [WB-1:0]            bitmap_mem [MAX_WORDS];
    logic [POS_W-1:0]         sample_mem [MAX_WORDS];
    logic [WB-1:0]            bm_rdata_reg;
    logic [POS_W-1:0]         smp_rdata_reg;

    // derived values
    logic [brs_pkg::SW_W-1:0] sw_eff;
    logic [POS_W-1:0]         len;
    logic [WPOS_W-1:0]        len_words;
    logic [WPOS_W-1:0]        nw;
    logic                     full;
    logic                     pos_oob;
    logic [WPOS_W-1:0]        pos_word;
    logic [OFF_W-1:0]         pos_off;
    logic                     cur_loaded;
    logic [WB-1:0]            raw;
    logic [WB-1:0]            vmask;
    logic [WB-1:0]            scan_m;
    logic [OFF_W:0]           scan_c;
    logic                     found;
    logic                     load_we;
    logic                     smp_we;

    always_comb
    begin
        if (sample_words_reg == '0)
            sw_eff = brs_pkg::SW_W'(1);
        else if (sample_words_reg > brs_pkg::SW_W'(brs_pkg::SW_MAX))
            sw_eff = brs_pkg::SW_W'(brs_pkg::SW_MAX);
        else
            sw_eff = sample_words_reg;
    end

    assign len        = (32'(bit_length_reg) > CAP) ? POS_W'(CAP) : bit_length_reg;
    assign len_words  = len[POS_W-1:OFF_W];
    assign nw         = len_words + WPOS_W'(len[OFF_W-1:0] != '0);
    assign full       = (32'(words_loaded_reg) >= 32'(MAX_WORDS));
    assign pos_oob    = (pos_reg >= len);
    assign pos_word   = pos_reg[POS_W-1:OFF_W];
    assign pos_off    = pos_reg[OFF_W-1:0];
    assign cur_loaded = (CMP_W'(cur_reg) < CMP_W'(words_loaded_reg));
    assign raw        = cur_loaded ? bm_rdata_reg : '0;

    // valid bits of the current word
    always_comb
    begin
        if (cur_reg < len_words)
            vmask = '1;
        else if (cur_reg == len_words)
            vmask = ~({WB{1'b1}} << len[OFF_W-1:0]);
        else
            vmask = '0;
    end

    // candidate bits of the current word for select scans
    always_comb
    begin
        case (op_reg)
            brs_pkg::OP_SEL1:  scan_m = raw & vmask;
            brs_pkg::OP_SEL0:  scan_m = ~raw & vmask;
            brs_pkg::OP_NEXT1:
                scan_m = raw & vmask & ((cur_reg == pos_word) ? ({WB{1'b1}} << pos_off) : '1);
            default:           scan_m = '0;
        endcase
    end

    assign scan_c = brs_pkg::pop64(scan_m);
    assign found  = (acc_reg <= POS_W'(scan_c));

    // status to the controller
    always_comb
    begin
        stat.is_load  = (op_reg == brs_pkg::OP_LOAD);
        stat.is_rank  = (op_reg == brs_pkg::OP_ACCESS) || (op_reg == brs_pkg::OP_RANK1)
                        || (op_reg == brs_pkg::OP_RANK0);
        case (op_reg)
            brs_pkg::OP_LOAD:                   stat.early = full;
            brs_pkg::OP_ACCESS, brs_pkg::OP_RANK1,
            brs_pkg::OP_RANK0, brs_pkg::OP_NEXT1: stat.early = pos_oob;
            brs_pkg::OP_SEL1, brs_pkg::OP_SEL0: stat.early = (pos_reg == '0);
            default:                            stat.early = 1'b1;
        endcase
        stat.div_last = (div_cnt_reg == 4'(WPOS_W - 1));
        stat.scan_end = (cur_reg == end_reg);
        stat.found    = found;
        stat.out_free = !out_valid_reg || out_ready;
    end

    assign load_we = (cmd == brs_pkg::CMD_LOAD);
    assign smp_we  = load_we && (blk_pos_reg == '0);

    // bitmap store
    always_ff @(posedge clk)
    begin
        if (load_we)
            bitmap_mem[IDX_W'(words_loaded_reg)] <= data_reg;
        if (cmd == brs_pkg::CMD_WORD_RD)
            bm_rdata_reg <= bitmap_mem[IDX_W'(cur_reg)];
    end

    // sample store
    always_ff @(posedge clk)
    begin
        if (smp_we)
            sample_mem[blk_idx_reg] <= running_ones_reg;
        if (cmd == brs_pkg::CMD_SAMPLE_RD)
            smp_rdata_reg <= sample_mem[IDX_W'(quo_reg)];
    end

    // configuration and load counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_words_reg <= brs_pkg::SW_W'(1);
            bit_length_reg   <= '0;
            words_loaded_reg <= '0;
            running_ones_reg <= '0;
            blk_pos_reg      <= '0;
            blk_idx_reg      <= '0;
        end
        else if (cfg_we && cfg_index == brs_pkg::REG_SAMPLE)
        begin
            sample_words_reg <= cfg_data[brs_pkg::SW_W-1:0];
            words_loaded_reg <= '0;
            running_ones_reg <= '0;
            blk_pos_reg      <= '0;
            blk_idx_reg      <= '0;
        end
        else
        begin
            if (cfg_we && cfg_index == brs_pkg::REG_LENGTH)
                bit_length_reg <= cfg_data;
            if (load_we)
            begin
                words_loaded_reg <= words_loaded_reg + CNT_W'(1);
                running_ones_reg <= running_ones_reg + POS_W'(brs_pkg::pop64(data_reg));
                if ((brs_pkg::SW_W'(blk_pos_reg) + brs_pkg::SW_W'(1)) == sw_eff)
                begin
                    blk_pos_reg <= '0;
                    blk_idx_reg <= blk_idx_reg + IDX_W'(1);
                end
                else
                begin
                    blk_pos_reg <= blk_pos_reg + brs_pkg::BLK_W'(1);
                end
            end
        end
    end

    // query datapath
    always_ff @(posedge clk)
    begin : work
        logic [brs_pkg::SW_W:0] t;
        logic                   ge;
        logic [WB-1:0]          w_last;
        logic [POS_W-1:0]       cnt;
        logic [KW-1:0]          k;
        logic                   done;
        logic [2:0]             sel;
        logic [3:0]             pc;
        t      = '0;
        ge     = 1'b0;
        w_last = '0;
        cnt    = '0;
        k      = '0;
        done   = 1'b0;
        sel    = '0;
        pc     = '0;
        case (cmd)
            brs_pkg::CMD_LATCH:
            begin
                op_reg   <= brs_pkg::op_t'(in_opcode);
                pos_reg  <= in_position;
                data_reg <= in_data_word;
            end
            brs_pkg::CMD_EARLY:
            begin
                res_bit_reg <= 1'b0;
                case (op_reg)
                    brs_pkg::OP_LOAD:
                    begin
                        res_ans_reg  <= POS_W'(words_loaded_reg);
                        res_stat_reg <= brs_pkg::STAT_RANGE;
                    end
                    brs_pkg::OP_ACCESS, brs_pkg::OP_RANK1, brs_pkg::OP_RANK0:
                    begin
                        res_ans_reg  <= '0;
                        res_stat_reg <= brs_pkg::STAT_RANGE;
                    end
                    brs_pkg::OP_SEL1, brs_pkg::OP_SEL0:
                    begin
                        res_ans_reg  <= '0;
                        res_stat_reg <= brs_pkg::STAT_ZERO;
                    end
                    brs_pkg::OP_NEXT1:
                    begin
                        res_ans_reg  <= len;
                        res_stat_reg <= brs_pkg::STAT_RANGE;
                    end
                    default:
                    begin
                        res_ans_reg  <= '0;
                        res_stat_reg <= brs_pkg::STAT_OK;
                    end
                endcase
            end
            brs_pkg::CMD_LOAD:
            begin
                res_bit_reg  <= 1'b0;
                res_ans_reg  <= POS_W'(words_loaded_reg + CNT_W'(1));
                res_stat_reg <= brs_pkg::STAT_OK;
            end
            brs_pkg::CMD_DIV_INIT:
            begin
                dvd_reg     <= pos_word;
                quo_reg     <= '0;
                rmd_reg     <= '0;
                div_cnt_reg <= '0;
            end
            brs_pkg::CMD_DIV_STEP:
            begin
                // one quotient bit per cycle
                t  = {rmd_reg, dvd_reg[WPOS_W-1]};
                ge = (t >= {1'b0, sw_eff});
                rmd_reg     <= ge ? brs_pkg::SW_W'(t - {1'b0, sw_eff})
                                  : brs_pkg::SW_W'(t);
                quo_reg     <= {quo_reg[WPOS_W-2:0], ge};
                dvd_reg     <= {dvd_reg[WPOS_W-2:0], 1'b0};
                div_cnt_reg <= div_cnt_reg + 4'd1;
            end
            brs_pkg::CMD_SAMPLE_RD:
            begin
                cur_reg <= pos_word - WPOS_W'(rmd_reg);
                end_reg <= pos_word;
            end
            brs_pkg::CMD_SAMPLE_ACC:
            begin
                acc_reg <= cur_loaded ? smp_rdata_reg : running_ones_reg;
            end
            brs_pkg::CMD_RANK_ACC:
            begin
                acc_reg <= acc_reg + POS_W'(brs_pkg::pop64(raw));
                cur_reg <= cur_reg + WPOS_W'(1);
            end
            brs_pkg::CMD_RANK_LAST:
            begin
                w_last = raw & ({WB{1'b1}} >> (OFF_W'(WB - 1) - pos_off));
                cnt    = acc_reg + POS_W'(brs_pkg::pop64(w_last));
                res_bit_reg  <= raw[pos_off];
                res_stat_reg <= brs_pkg::STAT_OK;
                if (op_reg == brs_pkg::OP_RANK1 || (op_reg == brs_pkg::OP_ACCESS && raw[pos_off]))
                    res_ans_reg <= cnt;
                else
                    res_ans_reg <= pos_reg + POS_W'(1) - cnt;
            end
            brs_pkg::CMD_SCAN_INIT:
            begin
                end_reg <= nw;
                if (op_reg == brs_pkg::OP_NEXT1)
                begin
                    acc_reg <= POS_W'(1);
                    cur_reg <= pos_word;
                end
                else
                begin
                    acc_reg <= pos_reg;
                    cur_reg <= '0;
                end
            end
            brs_pkg::CMD_SCAN_ACC:
            begin
                if (found)
                    m_reg <= scan_m;
                else
                begin
                    acc_reg <= acc_reg - POS_W'(scan_c);
                    cur_reg <= cur_reg + WPOS_W'(1);
                end
            end
            brs_pkg::CMD_NOT_FOUND:
            begin
                res_bit_reg  <= 1'b0;
                res_ans_reg  <= len;
                res_stat_reg <= brs_pkg::STAT_NOT_FOUND;
            end
            brs_pkg::CMD_FIND_BYTE:
            begin
                // pick the byte holding the k-th candidate
                k = acc_reg[KW-1:0];
                for (int i = 0; i < 8; i++)
                begin
                    pc = brs_pkg::pop8(m_reg[i*8 +: 8]);
                    if (!done)
                    begin
                        if (k <= KW'(pc))
                        begin
                            done = 1'b1;
                            sel  = 3'(i);
                        end
                        else
                        begin
                            k = k - KW'(pc);
                        end
                    end
                end
                byte_sel_reg <= sel;
                byte_reg     <= m_reg[sel*8 +: 8];
                acc_reg      <= POS_W'(k);
            end
            brs_pkg::CMD_FIND_BIT:
            begin
                // pick the bit inside the byte
                k = acc_reg[KW-1:0];
                for (int i = 0; i < 8; i++)
                begin
                    if (!done && byte_reg[i])
                    begin
                        if (k <= KW'(1))
                        begin
                            done = 1'b1;
                            sel  = 3'(i);
                        end
                        else
                        begin
                            k = k - KW'(1);
                        end
                    end
                end
                res_bit_reg  <= 1'b0;
                res_ans_reg  <= {cur_reg, byte_sel_reg, sel};
                res_stat_reg <= brs_pkg::STAT_OK;
            end
            default:
            begin
            end
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd == brs_pkg::CMD_EMIT)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd == brs_pkg::CMD_EMIT)
        begin
            out_bit_reg  <= res_bit_reg;
            out_ans_reg  <= res_ans_reg;
            out_stat_reg <= res_stat_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_bit_value = out_bit_reg;
    assign out_answer    = out_ans_reg;
    assign out_status    = out_stat_reg;

    a_wl_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(words_loaded_reg) <= 32'(MAX_WORDS))
        else $error("words loaded beyond capacity");

    a_cfg_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_we && cfg_index == brs_pkg::REG_SAMPLE) |=> (words_loaded_reg == '0
            && running_ones_reg == '0))
        else $error("block size write did not discard vector");

    a_err_bit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stat_reg != brs_pkg::STAT_OK) |-> !out_bit_reg)
        else $error("bit set on error result");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd == brs_pkg::CMD_EMIT) |-> (!out_valid_reg || out_ready))
        else $error("result overwritten while stalled");

endmodule

>>> design/bitvector_rank_select.sv
// Rank/select engine over a bit vector loaded as 64-bit words.
// Input stream: s_axis_tuser carries the opcode (load, access, rank1,
// rank0, select1, select0, select_next1), s_axis_tdata the position or
// select count and the data word. One result per transaction leaves on
// m_axis: bit value, answer and status.
// Configuration: cfg_we with cfg_index 0 sets the sample block size and
// discards the loaded vector; index 1 sets the bit length.
// Steps from accept to result valid:
//   load or early exits (range, zero index): dispatch, then emit
//   access/rank: 11-step block divider, sample read, then one read
//     per word from the block start up to the position's word
//   select1/select0/select_next1: one bitmap memory read per word
//     scanned until the candidate is found or the vector ends, then
//     byte and bit search when found
// One transaction is in flight at a time; the next is accepted once the
// result is in the output register, while it waits for m_axis_tready.
// A stalled receiver holds the result and keeps the engine in its last
// state. Reset clears the counters and configuration (block size 1,
// length 0); stored words are not cleared, unloaded words read as zero.
module bitvector_rank_select
#(
    parameter int MAX_WORDS = brs_pkg::MAX_WORDS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    // cfg: write enable, register index, write data
    input  logic                          cfg_we,
    input  logic [brs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [brs_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // tdata: position [16:0], data_word [80:17], zero fill [87:81]
    input  logic [87:0]                   s_axis_tdata,
    // tuser: opcode [2:0]
    input  logic [brs_pkg::OP_W-1:0]      s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // tdata: bit_value [0], answer [17:1], status [19:18], zero fill [23:20]
    output logic [23:0]                   m_axis_tdata
);

    brs_pkg::cmd_t                 cmd;
    brs_pkg::dp_status_t           stat;
    logic                          bit_value;
    logic [brs_pkg::POS_W-1:0]     answer;
    logic [brs_pkg::STAT_W-1:0]    status;

    brs_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    brs_dp #(.MAX_WORDS(MAX_WORDS)) u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_opcode     (s_axis_tuser),
        .in_position   (s_axis_tdata[16:0]),
        .in_data_word  (s_axis_tdata[80:17]),
        .out_ready     (m_axis_tready),
        .out_valid     (m_axis_tvalid),
        .out_bit_value (bit_value),
        .out_answer    (answer),
        .out_status    (status)
    );

    // pack result fields
    assign m_axis_tdata = {4'b0, status, answer, bit_value};

endmodule

>>> tb/bitvector_rank_select_tb.sv
`timescale 1ns / 1ps

module bitvector_rank_select_tb;

    localparam int CYCLE_LIMIT = 20000000;
    localparam int VEC_WORDS   = 1024;
    localparam int LEN_CAP     = VEC_WORDS * 64;

    typedef struct {
        bit        bit_value;
        bit [16:0] answer;
        bit [1:0]  status;
    } query_answer_t;

    // holds a copy of the vector state and the answers still owed by the block
    class rank_select_board;
        bit [63:0]     words [VEC_WORDS];
        bit [16:0]     block_ones [VEC_WORDS];
        int unsigned   ones_total;
        int unsigned   words_in;
        int unsigned   block_words;
        int unsigned   length_reg;
        int            errors;
        query_answer_t owed [$];

        function new();
            block_words = 1;
            length_reg  = 0;
            ones_total  = 0;
            words_in    = 0;
            errors      = 0;
        endfunction

        task report(string what);
            $display("mismatch: %s", what);
            errors++;
        endtask

        function void write_reg(brs_pkg::cfg_reg_t idx, bit [16:0] value);
            if (idx == brs_pkg::REG_SAMPLE)
            begin
                block_words = value[5:0];
                words_in    = 0;
                ones_total  = 0;
            end
            else
            begin
                length_reg = value;
            end
        endfunction

        function int unsigned eff_block();
            if (block_words == 0)
                return 1;
            if (block_words > 32)
                return 32;
            return block_words;
        endfunction

        function int unsigned eff_length();
            return (length_reg > LEN_CAP) ? LEN_CAP : length_reg;
        endfunction

        function int unsigned ones(bit [63:0] x);
            int unsigned c;
            c = 0;
            for (int i = 0; i < 64; i++)
                c += x[i];
            return c;
        endfunction

        function int unsigned nth_one(bit [63:0] x, int unsigned k);
            for (int i = 0; i < 64; i++)
            begin
                if (x[i])
                begin
                    if (k <= 1)
                        return i;
                    k--;
                end
            end
            return 0;
        endfunction

        function bit [63:0] word_at(int unsigned w);
            return (w < words_in) ? words[w] : 64'd0;
        endfunction

        function bit [63:0] live_mask(int unsigned w, int unsigned len);
            int unsigned lo;
            lo = w * 64;
            if (lo >= len)
                return 64'd0;
            if (lo + 64 <= len)
                return '1;
            return (64'd1 << (len - lo)) - 64'd1;
        endfunction

        // ones up to and including pos, using the stored block count
        function int unsigned ones_through(int unsigned pos);
            int unsigned w, blk, first, cnt;
            w     = pos / 64;
            blk   = w / eff_block();
            first = blk * eff_block();
            cnt   = (first < words_in) ? block_ones[blk] : ones_total;
            for (int unsigned j = first; j < w; j++)
                cnt += ones(word_at(j));
            cnt += ones(word_at(w) & ((64'd2 << (pos % 64)) - 64'd1));
            return cnt;
        endfunction

        function void note(brs_pkg::op_t op, bit [16:0] pos, bit [63:0] data);
            query_answer_t e;
            int unsigned   len, nw, w, r, c, r1;
            bit            b;
            bit [63:0]     m;
            len = eff_length();
            nw  = (len + 63) / 64;
            e   = '{1'b0, 17'd0, brs_pkg::STAT_OK};
            m   = '0;
            case (op)
                brs_pkg::OP_LOAD:
                begin
                    if (words_in >= VEC_WORDS)
                    begin
                        e.answer = 17'(words_in);
                        e.status = brs_pkg::STAT_RANGE;
                    end
                    else
                    begin
                        if (words_in % eff_block() == 0)
                            block_ones[words_in / eff_block()] = 17'(ones_total);
                        words[words_in] = data;
                        ones_total = (ones_total + ones(data)) & 32'h1FFFF;
                        words_in++;
                        e.answer = 17'(words_in);
                    end
                end
                brs_pkg::OP_ACCESS, brs_pkg::OP_RANK1, brs_pkg::OP_RANK0:
                begin
                    if (pos >= len)
                    begin
                        e.status = brs_pkg::STAT_RANGE;
                    end
                    else
                    begin
                        m  = word_at(pos / 64);
                        b  = m[pos % 64];
                        r1 = ones_through(pos);
                        e.bit_value = b;
                        if (op == brs_pkg::OP_RANK1 || (op == brs_pkg::OP_ACCESS && b))
                            e.answer = 17'(r1);
                        else
                            e.answer = 17'(pos + 1 - r1);
                    end
                end
                brs_pkg::OP_SEL1, brs_pkg::OP_SEL0:
                begin
                    if (pos == 0)
                    begin
                        e.status = brs_pkg::STAT_ZERO;
                    end
                    else
                    begin
                        r = pos;
                        for (w = 0; w < nw; w++)
                        begin
                            m = (op == brs_pkg::OP_SEL1) ? word_at(w) : ~word_at(w);
                            m &= live_mask(w, len);
                            c = ones(m);
                            if (r <= c)
                                break;
                            r -= c;
                        end
                        if (w < nw)
                            e.answer = 17'(w * 64 + nth_one(m, r));
                        else
                        begin
                            e.answer = 17'(len);
                            e.status = brs_pkg::STAT_NOT_FOUND;
                        end
                    end
                end
                brs_pkg::OP_NEXT1:
                begin
                    if (pos >= len)
                    begin
                        e.answer = 17'(len);
                        e.status = brs_pkg::STAT_RANGE;
                    end
                    else
                    begin
                        for (w = pos / 64; w < nw; w++)
                        begin
                            m = word_at(w) & live_mask(w, len);
                            if (w == pos / 64)
                                m &= ~64'd0 << (pos % 64);
                            if (m != 0)
                                break;
                        end
                        if (w < nw)
                            e.answer = 17'(w * 64 + nth_one(m, 1));
                        else
                        begin
                            e.answer = 17'(len);
                            e.status = brs_pkg::STAT_NOT_FOUND;
                        end
                    end
                end
                default:
                begin
                end
            endcase
            owed.push_back(e);
        endfunction

        task check(bit b, bit [16:0] ans, bit [1:0] st);
            query_answer_t e;
            if (owed.size() == 0)
            begin
                report($sformatf("result with nothing owed (ans %0d)", ans));
                return;
            end
            e = owed.pop_front();
            if (b != e.bit_value)
                report($sformatf("bit_value %0d, want %0d", b, e.bit_value));
            if (ans != e.answer)
                report($sformatf("answer %0d, want %0d", ans, e.answer));
            if (st != e.status)
                report($sformatf("status %0d, want %0d", st, e.status));
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [brs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [brs_pkg::CFG_W-1:0]     cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [87:0] s_axis_tdata = '0;
    logic [brs_pkg::OP_W-1:0] s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;

    rank_select_board board = new();
    int  cycles = 0;
    int  sent = 0;
    bit  calm = 1'b0;
    bit  hold_go = 1'b0;
    int  hold_left = 0;

    bitvector_rank_select dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("bitvector_rank_select_tb NOT OK");
            $finish;
        end
    end

    // result side: check each transaction, random stalls and one long hold-off
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            board.check(m_axis_tdata[0], m_axis_tdata[17:1], m_axis_tdata[19:18]);
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else if (hold_go)
        begin
            hold_go = 1'b0;
            hold_left = 300;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= calm || ($urandom_range(0, 99) >= 28);
        end
    end

    task automatic write_reg(brs_pkg::cfg_reg_t idx, bit [16:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        board.write_reg(idx, value);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // send one transaction, at random with a random gap before it
    task automatic send(brs_pkg::op_t op, bit [16:0] pos, bit [63:0] data);
        if (!calm && $urandom_range(0, 99) < 28)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {7'd0, data, pos};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        board.note(op, pos, data);
        sent++;
    endtask

    // stop offering and wait for every owed answer
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (board.owed.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    function automatic bit [63:0] rand_word();
        case ($urandom_range(0, 9))
            0: return '1;
            1: return '0;
            2: return 64'd1 << $urandom_range(0, 63);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic random_query();
        brs_pkg::op_t op;
        int unsigned  len;
        bit [16:0]    pos;
        len = board.eff_length();
        op  = ($urandom_range(0, 99) < 3) ? brs_pkg::OP_RSVD
                                          : brs_pkg::op_t'($urandom_range(1, 6));
        if ($urandom_range(0, 99) < 5)
            pos = 17'($urandom_range(0, 17'h1FFFF));
        else if (op == brs_pkg::OP_SEL1 || op == brs_pkg::OP_SEL0)
            pos = 17'($urandom_range(0, len + 2));
        else
            pos = 17'($urandom_range(0, len));
        send(op, pos, {$urandom, $urandom});
    endtask

    initial
    begin
        int unsigned phase, nwords, len, nq, pick;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: three words, length ending mid-word
        write_reg(brs_pkg::REG_SAMPLE, 17'd2);
        write_reg(brs_pkg::REG_LENGTH, 17'd130);
        send(brs_pkg::OP_LOAD, 17'd0, '1);
        send(brs_pkg::OP_LOAD, 17'd0, '0);
        send(brs_pkg::OP_LOAD, 17'd0, 64'h8000_0000_0000_0001);
        send(brs_pkg::OP_ACCESS, 17'd0, '0);
        send(brs_pkg::OP_ACCESS, 17'd129, '0);
        send(brs_pkg::OP_ACCESS, 17'd130, '0);
        send(brs_pkg::OP_RANK1, 17'd129, '0);
        send(brs_pkg::OP_RANK0, 17'd64, '0);
        send(brs_pkg::OP_RANK0, 17'd0, '0);
        send(brs_pkg::OP_SEL1, 17'd0, '0);
        send(brs_pkg::OP_SEL1, 17'd1, '0);
        send(brs_pkg::OP_SEL1, 17'd65, '0);
        send(brs_pkg::OP_SEL1, 17'd66, '0);
        send(brs_pkg::OP_SEL0, 17'd1, '0);
        send(brs_pkg::OP_SEL0, 17'd64, '0);
        send(brs_pkg::OP_SEL0, 17'd200, '0);
        send(brs_pkg::OP_NEXT1, 17'd0, '0);
        send(brs_pkg::OP_NEXT1, 17'd65, '0);
        send(brs_pkg::OP_NEXT1, 17'd129, '0);
        send(brs_pkg::OP_NEXT1, 17'd130, '0);
        send(brs_pkg::OP_RSVD, 17'h1FFFF, '1);
        send(brs_pkg::OP_LOAD, 17'h1FFFF, 64'h0123_4567_89AB_CDEF);
        send(brs_pkg::OP_RANK1, 17'd129, '0);
        drain();

        // random phases; phase 1 fills the whole vector past its capacity
        phase = 0;
        while (sent < 1500)
        begin
            phase++;
            calm = (phase == 2);
            if (phase == 1)
            begin
                write_reg(brs_pkg::REG_SAMPLE, 17'd63);
                write_reg(brs_pkg::REG_LENGTH, 17'h1FFFF);
                for (int i = 0; i < VEC_WORDS + 6; i++)
                    send(brs_pkg::OP_LOAD, 17'($urandom_range(0, 17'h1FFFF)), rand_word());
                for (int i = 0; i < 20; i++)
                    random_query();
                send(brs_pkg::OP_ACCESS, 17'h10000, '0);
                send(brs_pkg::OP_RANK1, 17'hFFFF, '0);
                send(brs_pkg::OP_NEXT1, 17'hFFFF, '0);
            end
            else
            begin
                pick = $urandom_range(0, 9);
                write_reg(brs_pkg::REG_SAMPLE, (pick == 0) ? 17'd0 : (pick == 1) ? 17'd32 :
                          (pick == 2) ? 17'd1 : 17'($urandom_range(1, 8)));
                nwords = $urandom_range(1, 40);
                case ($urandom_range(0, 11))
                    0: len = $urandom_range(0, 17'h1FFFF);
                    1: len = nwords * 64 + $urandom_range(1, 200);
                    2: len = 0;
                    default: len = nwords * 64 - $urandom_range(0, 63);
                endcase
                write_reg(brs_pkg::REG_LENGTH, 17'(len));
                if (phase == 3)
                    hold_go = 1'b1;
                for (int i = 0; i < nwords; i++)
                    send(brs_pkg::OP_LOAD, 17'($urandom_range(0, 17'h1FFFF)), rand_word());
                nq = $urandom_range(20, 60);
                for (int i = 0; i < nq; i++)
                begin
                    if ($urandom_range(0, 99) < 5)
                        send(brs_pkg::OP_LOAD, 17'd0, rand_word());
                    else
                        random_query();
                end
            end
            drain();
        end

        calm = 1'b0;
        drain();
        repeat (20) @(posedge clk);
        if (board.errors == 0 && board.owed.size() == 0)
            $display("bitvector_rank_select_tb OK");
        else
            $display("bitvector_rank_select_tb NOT OK");
        $finish;
    end

endmodule
